// File: hw/rtl/mti_pkg.sv
// ----------------------------------------------------------------------------
// mti_pkg: shared definitions of the monotone table interpolator
// Table geometry, datapath widths, request and status codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package mti_pkg;

  // Table geometry and stored word width.
  localparam int unsigned TABLE_DEPTH = 65;
  localparam int unsigned VALUE_WIDTH = 32;

  // Fixed width of the key and value fields at the ports.
  localparam int unsigned FieldW = 32;
  localparam int unsigned IndexW = 7;

  localparam int unsigned AddrW  = $clog2(TABLE_DEPTH);
  localparam int unsigned IdxExtW = (AddrW > IndexW) ? AddrW : IndexW;
  // Bits of a port field that are kept before sign extension.
  localparam int unsigned InW    = (VALUE_WIDTH < FieldW) ? VALUE_WIDTH : FieldW;
  // Width of key and value differences, products halves and the quotient.
  localparam int unsigned NW     = VALUE_WIDTH + 1;
  // Width of the shared adder: one guard bit above NW + 1.
  localparam int unsigned UW     = VALUE_WIDTH + 3;
  localparam int unsigned ExtW   = (UW > FieldW) ? UW : FieldW;
  localparam int unsigned CntW   = $clog2(NW + 1);

  localparam logic [AddrW-1:0] LastAddr = AddrW'(TABLE_DEPTH - 1);
  localparam logic [AddrW-1:0] MidInit  = AddrW'((TABLE_DEPTH - 1) / 2);

  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqQuery = 1'b1;

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatRange = 2'd1,
    StatFlat  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_KLO,
    S_KHI,
    S_KHI_W,
    S_MID,
    S_MID_W,
    S_VA,
    S_VB,
    S_VB_W,
    S_ABS,
    S_MUL,
    S_DIV,
    S_ACC,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

// File: hw/rtl/mti_ram.sv
// ----------------------------------------------------------------------------
// mti_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mti_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/monotone_table_interpolator.sv
// ----------------------------------------------------------------------------
// monotone_table_interpolator: bisection lookup with linear interpolation
// Key and value tables in RAM, a small sequencer and one shared adder that
// does the differences, a shift-and-add multiply and a restoring divide.
// ----------------------------------------------------------------------------
// A load word writes one key/value pair if its index is in range, and its
// result reaches the output register from the done state once that register
// is free. A query word fetches the end keys, then runs bisection steps (one
// key RAM read each, about six steps for 65 entries), reads the segment values
// and forms the differences, runs the serial multiply and divide through the
// shared adder, and then finishes. Words are taken one at a time; the next
// word is accepted only in the idle state, after the result has entered the
// output register; a finished result waits in the output register while the
// next word is accepted. Reading a table entry that was never loaded gives an
// undefined result.
`default_nettype none

module monotone_table_interpolator (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           req_type_i,
  input  wire logic [mti_pkg::IndexW-1:0]     entry_index_i,
  input  wire logic signed [mti_pkg::FieldW-1:0] entry_key_i,
  input  wire logic signed [mti_pkg::FieldW-1:0] entry_value_i,
  input  wire logic signed [mti_pkg::FieldW-1:0] query_key_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [mti_pkg::FieldW-1:0]   result_value_o,
  output logic [1:0]                          status_o
);

  localparam int unsigned W  = mti_pkg::VALUE_WIDTH;
  localparam int unsigned AW = mti_pkg::AddrW;
  localparam int unsigned NW = mti_pkg::NW;
  localparam int unsigned UW = mti_pkg::UW;

  mti_pkg::state_e state_q, state_d;

  // Bisection state.
  logic [AW-1:0]       lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic signed [W-1:0] x_q, x_d, klo_q, klo_d, khi_q, khi_d;
  logic                ge_lo_q, ge_lo_d, le_hi_q, le_hi_d;
  // Chosen segment.
  logic [AW-1:0]       seg_a_q, seg_a_d, seg_b_q, seg_b_d;
  logic signed [W-1:0] ka_q, ka_d, kb_q, kb_d, va_q, va_d;
  // Arithmetic registers: acc_hi/acc_lo form the double-width product,
  // then the remainder and the dividend shifting into the quotient.
  logic [NW-1:0]       dk_q, dk_d, mag_q, mag_d, acc_hi_q, acc_hi_d, acc_lo_q, acc_lo_d;
  logic                dv_neg_q, dv_neg_d;
  logic [mti_pkg::CntW-1:0] cnt_q, cnt_d;
  // Result waiting for the output register.
  logic signed [mti_pkg::FieldW-1:0] res_q, res_d;
  mti_pkg::status_e    stat_q, stat_d;
  // Output register.
  logic                out_valid_q, out_valid_d;
  logic signed [mti_pkg::FieldW-1:0] out_value_q;
  mti_pkg::status_e    out_status_q;
  logic                out_load;

  // RAM ports.
  logic                key_we;
  logic [AW-1:0]       waddr, key_raddr, val_raddr;
  logic [W-1:0]        key_wdata, val_wdata, key_rdata, val_rdata;

  // Shared adder.
  logic [UW-1:0]       alu_a, alu_b, alu_sum;
  logic                alu_sub;

  // Shared comparator of the query key against the key read from RAM.
  logic                x_lt_rd, x_eq_rd;

  logic                in_accept, idx_ok, cnt_last, go_low, go_high;
  logic                lo_next_mid, mid_next_hi;
  logic [mti_pkg::IdxExtW-1:0] idx_ext;

  assign in_stall_o = (state_q != mti_pkg::S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign idx_ext = mti_pkg::IdxExtW'(entry_index_i);
  assign idx_ok  = (32'(entry_index_i) < 32'(mti_pkg::TABLE_DEPTH));
  assign waddr   = idx_ext[AW-1:0];
  assign key_we  = in_accept && (req_type_i == mti_pkg::ReqLoad) && idx_ok;
  assign key_wdata = W'($signed(entry_key_i[mti_pkg::InW-1:0]));
  assign val_wdata = W'($signed(entry_value_i[mti_pkg::InW-1:0]));

  mti_ram #(
    .Width (W),
    .Depth (mti_pkg::TABLE_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (waddr),
    .wdata_i (key_wdata),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  mti_ram #(
    .Width (W),
    .Depth (mti_pkg::TABLE_DEPTH)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (waddr),
    .wdata_i (val_wdata),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + UW'(alu_sub);

  assign x_lt_rd = (x_q < $signed(key_rdata));
  assign x_eq_rd = (x_q == $signed(key_rdata));

  // Decisions of one bisection step, valid while the middle key is on the bus.
  assign go_low      = ge_lo_q && x_lt_rd;
  assign go_high     = !x_lt_rd && le_hi_q;
  assign lo_next_mid = (({1'b0, lo_q} + (AW+1)'(1)) == {1'b0, mid_q});
  assign mid_next_hi = (({1'b0, mid_q} + (AW+1)'(1)) == {1'b0, hi_q});
  assign cnt_last    = (cnt_q == mti_pkg::CntW'(NW - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mti_pkg::S_IDLE: begin
        if (in_accept) begin
          state_d = (req_type_i == mti_pkg::ReqQuery) ? mti_pkg::S_KLO : mti_pkg::S_DONE;
        end
      end
      mti_pkg::S_KLO:   state_d = mti_pkg::S_KHI;
      mti_pkg::S_KHI:   state_d = mti_pkg::S_KHI_W;
      mti_pkg::S_KHI_W: state_d = mti_pkg::S_MID;
      mti_pkg::S_MID:   state_d = mti_pkg::S_MID_W;
      mti_pkg::S_MID_W: begin
        priority if (go_low) begin
          state_d = lo_next_mid ? mti_pkg::S_VA : mti_pkg::S_MID;
        end else if (go_high) begin
          state_d = mid_next_hi ? mti_pkg::S_VA : mti_pkg::S_MID;
        end else begin
          state_d = mti_pkg::S_DONE;
        end
      end
      mti_pkg::S_VA:    state_d = mti_pkg::S_VB;
      mti_pkg::S_VB:    state_d = mti_pkg::S_VB_W;
      mti_pkg::S_VB_W:  state_d = mti_pkg::S_ABS;
      mti_pkg::S_ABS:   state_d = (dk_q == '0) ? mti_pkg::S_DONE : mti_pkg::S_MUL;
      mti_pkg::S_MUL:   state_d = cnt_last ? mti_pkg::S_DIV : mti_pkg::S_MUL;
      mti_pkg::S_DIV:   state_d = cnt_last ? mti_pkg::S_ACC : mti_pkg::S_DIV;
      mti_pkg::S_ACC:   state_d = mti_pkg::S_DONE;
      mti_pkg::S_DONE: begin
        if (out_load) begin
          state_d = mti_pkg::S_IDLE;
        end
      end
      default: state_d = mti_pkg::S_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    logic [AW:0]                       mid_sum;
    logic [NW:0]                       rem_sh;
    logic signed [mti_pkg::ExtW-1:0]   res_ext;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    x_d       = x_q;
    klo_d     = klo_q;
    khi_d     = khi_q;
    ge_lo_d   = ge_lo_q;
    le_hi_d   = le_hi_q;
    seg_a_d   = seg_a_q;
    seg_b_d   = seg_b_q;
    ka_d      = ka_q;
    kb_d      = kb_q;
    va_d      = va_q;
    dk_d      = dk_q;
    mag_d     = mag_q;
    dv_neg_d  = dv_neg_q;
    acc_hi_d  = acc_hi_q;
    acc_lo_d  = acc_lo_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    stat_d    = stat_q;
    key_raddr = '0;
    val_raddr = seg_a_q;
    alu_a     = '0;
    alu_b     = '0;
    alu_sub   = 1'b0;
    mid_sum   = '0;
    rem_sh    = {acc_hi_q, acc_lo_q[NW-1]};
    res_ext   = mti_pkg::ExtW'($signed(alu_sum));

    unique case (state_q)
      mti_pkg::S_IDLE: begin
        x_d   = W'($signed(query_key_i[mti_pkg::InW-1:0]));
        lo_d  = '0;
        hi_d  = mti_pkg::LastAddr;
        mid_d = mti_pkg::MidInit;
        res_d = '0;
        stat_d = idx_ok ? mti_pkg::StatOk : mti_pkg::StatRange;
      end
      mti_pkg::S_KLO: begin
        key_raddr = '0;
      end
      mti_pkg::S_KHI: begin
        key_raddr = mti_pkg::LastAddr;
        klo_d     = key_rdata;
        ge_lo_d   = !x_lt_rd;
      end
      mti_pkg::S_KHI_W: begin
        khi_d   = key_rdata;
        le_hi_d = x_lt_rd || x_eq_rd;
      end
      mti_pkg::S_MID: begin
        key_raddr = mid_q;
      end
      mti_pkg::S_MID_W: begin
        res_d  = '0;
        stat_d = mti_pkg::StatRange;
        priority if (go_low) begin
          seg_a_d = lo_q;
          seg_b_d = mid_q;
          ka_d    = klo_q;
          kb_d    = key_rdata;
          hi_d    = mid_q;
          khi_d   = key_rdata;
          le_hi_d = 1'b1;
        end else if (go_high) begin
          seg_a_d = mid_q;
          seg_b_d = hi_q;
          ka_d    = key_rdata;
          kb_d    = khi_q;
          lo_d    = mid_q;
          klo_d   = key_rdata;
          ge_lo_d = 1'b1;
        end else begin
          seg_a_d = seg_a_q;
        end
        mid_sum = {1'b0, lo_d} + {1'b0, hi_d};
        mid_d   = mid_sum[AW:1];
      end
      mti_pkg::S_VA: begin
        val_raddr = seg_a_q;
        alu_a     = UW'(kb_q);
        alu_b     = UW'(ka_q);
        alu_sub   = 1'b1;
        dk_d      = alu_sum[NW-1:0];
      end
      mti_pkg::S_VB: begin
        val_raddr = seg_b_q;
        va_d      = val_rdata;
        alu_a     = UW'(x_q);
        alu_b     = UW'(ka_q);
        alu_sub   = 1'b1;
        acc_lo_d  = alu_sum[NW-1:0];
      end
      mti_pkg::S_VB_W: begin
        alu_a    = UW'($signed(val_rdata));
        alu_b    = UW'(va_q);
        alu_sub  = 1'b1;
        mag_d    = alu_sum[NW-1:0];
        dv_neg_d = alu_sum[UW-1];
      end
      mti_pkg::S_ABS: begin
        // Magnitude of the value difference; a flat segment ends here.
        alu_b    = UW'($signed(mag_q));
        alu_sub  = dv_neg_q;
        mag_d    = alu_sum[NW-1:0];
        acc_hi_d = '0;
        cnt_d    = '0;
        res_d    = '0;
        stat_d   = mti_pkg::StatFlat;
      end
      mti_pkg::S_MUL: begin
        // Shift-and-add, least significant multiplier bit first.
        alu_a    = UW'(acc_hi_q);
        alu_b    = acc_lo_q[0] ? UW'(mag_q) : '0;
        acc_hi_d = alu_sum[NW:1];
        acc_lo_d = {alu_sum[0], acc_lo_q[NW-1:1]};
        cnt_d    = cnt_last ? '0 : cnt_q + mti_pkg::CntW'(1);
      end
      mti_pkg::S_DIV: begin
        // Restoring division; the remainder stays below the divisor.
        alu_a   = UW'(rem_sh);
        alu_b   = UW'(dk_q);
        alu_sub = 1'b1;
        if (alu_sum[UW-1]) begin
          acc_hi_d = rem_sh[NW-1:0];
        end else begin
          acc_hi_d = alu_sum[NW-1:0];
        end
        acc_lo_d = {acc_lo_q[NW-2:0], !alu_sum[UW-1]};
        cnt_d    = cnt_last ? '0 : cnt_q + mti_pkg::CntW'(1);
      end
      mti_pkg::S_ACC: begin
        alu_a   = UW'(va_q);
        alu_b   = UW'(acc_lo_q);
        alu_sub = dv_neg_q;
        res_d   = res_ext[mti_pkg::FieldW-1:0];
        stat_d  = mti_pkg::StatOk;
      end
      mti_pkg::S_DONE: begin
        res_d = res_q;
      end
      default: begin
        res_d = res_q;
      end
    endcase
  end

  assign out_load    = (state_q == mti_pkg::S_DONE) && (!out_valid_q || !out_stall_i);
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mti_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    x_q      <= x_d;
    klo_q    <= klo_d;
    khi_q    <= khi_d;
    ge_lo_q  <= ge_lo_d;
    le_hi_q  <= le_hi_d;
    seg_a_q  <= seg_a_d;
    seg_b_q  <= seg_b_d;
    ka_q     <= ka_d;
    kb_q     <= kb_d;
    va_q     <= va_d;
    dk_q     <= dk_d;
    mag_q    <= mag_d;
    dv_neg_q <= dv_neg_d;
    acc_hi_q <= acc_hi_d;
    acc_lo_q <= acc_lo_d;
    cnt_q    <= cnt_d;
    res_q    <= res_d;
    stat_q   <= stat_d;
    if (out_load) begin
      out_value_q  <= res_q;
      out_status_q <= stat_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign status_o       = out_status_q;

endmodule

`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the monotone table interpolator
// Loads key/value tables, sends load and query words under random bursts and
// output stalls, and checks every result word against an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam longint FieldMin   = 64'shFFFF_FFFF_8000_0000;
  localparam longint FieldMax   = 64'sh0000_0000_7FFF_FFFF;
  localparam int     CycleLimit = 3_000_000;
  localparam int     RandomWords = 1200;
  localparam int     TailCycles = 200;

  localparam int unsigned IndexW      = mti_pkg::IndexW;
  localparam int unsigned FieldW      = mti_pkg::FieldW;
  localparam int unsigned InW         = mti_pkg::InW;
  localparam int unsigned TABLE_DEPTH = mti_pkg::TABLE_DEPTH;

  typedef struct {
    logic                     req;
    logic [IndexW-1:0]        idx;
    logic signed [FieldW-1:0] ekey;
    logic signed [FieldW-1:0] evalue;
    logic signed [FieldW-1:0] qkey;
  } req_word_t;

  typedef struct {
    logic signed [FieldW-1:0] value;
    mti_pkg::status_e         status;
  } answer_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     req_type_i = mti_pkg::ReqLoad;
  logic [IndexW-1:0]        entry_index_i = '0;
  logic signed [FieldW-1:0] entry_key_i = '0;
  logic signed [FieldW-1:0] entry_value_i = '0;
  logic signed [FieldW-1:0] query_key_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [FieldW-1:0] result_value_o;
  logic [1:0]               status_o;

  req_word_t pending_words[$];
  answer_t   awaited_answers[$];

  // Predictor copy of the tables, updated as words are accepted.
  longint model_keys[TABLE_DEPTH];
  longint model_values[TABLE_DEPTH];
  // Keys as the stimulus planner expects them once queued words are applied.
  longint plan_keys[TABLE_DEPTH];

  int fault_count = 0;
  int cycle_count = 0;
  bit word_taken  = 1'b0;
  int burst_left  = 0;
  int gap_left    = 0;
  int phase_left  = 0;

  monotone_table_interpolator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .entry_index_i  (entry_index_i),
    .entry_key_i    (entry_key_i),
    .entry_value_i  (entry_value_i),
    .query_key_i    (query_key_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .status_o       (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint field_to_long(input logic [FieldW-1:0] f);
    return longint'($signed(f[InW-1:0]));
  endfunction

  function automatic void interpolate_word(input req_word_t w, output answer_t a);
    longint      x, dk, dv, dq, res;
    int unsigned lo, hi, mid, sa, sb, n;
    bit          found;
    logic [63:0] mag, quo;
    logic [127:0] prod;
    a.value  = '0;
    a.status = mti_pkg::StatRange;
    if (w.req == mti_pkg::ReqLoad) begin
      if (int'(w.idx) < TABLE_DEPTH) begin
        model_keys[w.idx]   = field_to_long(w.ekey);
        model_values[w.idx] = field_to_long(w.evalue);
        a.status = mti_pkg::StatOk;
      end
      return;
    end
    x     = field_to_long(w.qkey);
    lo    = 0;
    hi    = TABLE_DEPTH - 1;
    mid   = (TABLE_DEPTH - 1) / 2;
    sa    = 0;
    sb    = 0;
    found = 1'b0;
    for (n = 0; n < TABLE_DEPTH && !found; n++) begin
      if (model_keys[lo] <= x && x < model_keys[mid]) begin
        if (lo + 1 == mid) begin
          sa = lo;
          sb = mid;
          found = 1'b1;
        end else begin
          hi  = mid;
          mid = (hi + lo) / 2;
        end
      end else if (model_keys[mid] <= x && x <= model_keys[hi]) begin
        if (mid + 1 == hi) begin
          sa = mid;
          sb = hi;
          found = 1'b1;
        end else begin
          lo  = mid;
          mid = (hi + lo) / 2;
        end
      end
    end
    if (!found) return;
    dk = model_keys[sb] - model_keys[sa];
    if (dk == 0) begin
      a.status = mti_pkg::StatFlat;
      return;
    end
    dv   = model_values[sb] - model_values[sa];
    dq   = x - model_keys[sa];
    mag  = (dv < 0) ? 64'(-dv) : 64'(dv);
    // The product is kept exact; the quotient is truncated toward zero.
    prod = {64'd0, mag} * {64'd0, 64'(dq)};
    quo  = 64'(prod / {64'd0, 64'(dk)});
    res  = (dv < 0) ? model_values[sa] - longint'(quo) : model_values[sa] + longint'(quo);
    a.value  = FieldW'(res);
    a.status = mti_pkg::StatOk;
  endfunction

  function automatic longint rand_between(input longint a, input longint b);
    logic [63:0] span, r;
    if (b <= a) return a;
    span = 64'(b - a) + 64'd1;
    r    = {$urandom, $urandom};
    return a + longint'(r % span);
  endfunction

  function automatic longint random_value();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? FieldMax : FieldMin;
    return longint'($signed($urandom));
  endfunction

  task automatic push_load(input logic [IndexW-1:0] idx, input longint k, input longint v);
    req_word_t w;
    w.req    = mti_pkg::ReqLoad;
    w.idx    = idx;
    w.ekey   = FieldW'(k);
    w.evalue = FieldW'(v);
    w.qkey   = $urandom;
    pending_words.push_back(w);
    if (int'(idx) < TABLE_DEPTH) plan_keys[idx] = field_to_long(w.ekey);
  endtask

  task automatic push_query(input longint q);
    req_word_t w;
    w.req    = mti_pkg::ReqQuery;
    w.idx    = IndexW'($urandom);
    w.ekey   = $urandom;
    w.evalue = $urandom;
    w.qkey   = FieldW'(q);
    pending_words.push_back(w);
  endtask

  // Writes a whole ascending table; a zero step now and then leaves a flat segment.
  task automatic fill_table(input longint max_step);
    longint k, step;
    int     i;
    k = rand_between(FieldMin, FieldMax - longint'(TABLE_DEPTH - 1) * max_step);
    for (i = 0; i < TABLE_DEPTH; i++) begin
      push_load(IndexW'(i), k, random_value());
      step = ($urandom_range(0, 7) == 0) ? 0 : rand_between(1, max_step);
      k    = (k + step > FieldMax) ? FieldMax : k + step;
    end
  endtask

  task automatic wait_for_drain();
    while (pending_words.size() != 0 || awaited_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_fault(input string what);
    if (fault_count < 10) $display("%0t ns: %s", $time, what);
    fault_count++;
  endtask

  // Sender: bursts of words with random gaps, occasionally a long unbroken burst.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || word_taken)) begin
      word_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() == 0) begin
        in_valid_i <= 1'b0;
      end else begin
        req_type_i    <= pending_words[0].req;
        entry_index_i <= pending_words[0].idx;
        entry_key_i   <= pending_words[0].ekey;
        entry_value_i <= pending_words[0].evalue;
        query_key_i   <= pending_words[0].qkey;
        in_valid_i    <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // Receiver: alternating stall and free windows of random length.
  always @(negedge clk_i) begin
    if (phase_left > 0) begin
      phase_left--;
    end else begin
      out_stall_i <= !out_stall_i;
      if (!out_stall_i) begin
        phase_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 4);
      end else begin
        phase_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 800)
                                                 : $urandom_range(1, 60);
      end
    end
  end

  always @(posedge clk_i) begin
    req_word_t w;
    answer_t   ans, exp;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        w.req    = req_type_i;
        w.idx    = entry_index_i;
        w.ekey   = entry_key_i;
        w.evalue = entry_value_i;
        w.qkey   = query_key_i;
        interpolate_word(w, ans);
        awaited_answers.push_back(ans);
        void'(pending_words.pop_front());
        word_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (awaited_answers.size() == 0) begin
          report_fault($sformatf("unexpected result word: value %0d status %0d",
                                 result_value_o, status_o));
        end else begin
          exp = awaited_answers.pop_front();
          if (result_value_o !== exp.value || status_o !== exp.status) begin
            report_fault($sformatf("mismatch: expected value %0d status %0d, got %0d %0d",
                                   exp.value, exp.status, result_value_o, status_o));
          end
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int     i, count, next_reload, pick;
    longint lo, hi, q, t;

    // Directed table: extreme first key, steepest falling first segment, and a
    // flat pair at the top of the key range.
    for (i = 0; i < TABLE_DEPTH; i++) begin
      if (i >= TABLE_DEPTH - 2) t = FieldMax;
      else t = FieldMin + longint'(i) * 64'sd67108864;
      push_load(IndexW'(i), t, (i == 0) ? FieldMax : (i == 1) ? FieldMin : random_value());
    end
    push_query(FieldMin);
    push_query(FieldMin + 64'sd33554432);
    push_query(FieldMin + 64'sd67108863);
    push_query(plan_keys[32]);
    push_query(plan_keys[32] + 12345);
    push_query(FieldMax - 1);
    push_query(FieldMax);
    push_query(0);
    push_load(IndexW'(127), -1, -1);
    push_load(IndexW'(TABLE_DEPTH), 0, 0);
    push_load(IndexW'(TABLE_DEPTH - 1), FieldMax, FieldMin);
    push_query(FieldMax);
    // Query below the first key, then above the last key.
    push_load(IndexW'(0), FieldMin + 1, FieldMin);
    push_query(FieldMin);
    push_query(FieldMin + 1);
    push_load(IndexW'(TABLE_DEPTH - 2), FieldMax - 1, FieldMax);
    push_load(IndexW'(TABLE_DEPTH - 1), FieldMax - 1, 0);
    push_query(FieldMax);
    push_query(FieldMax - 1);
    // A key out of order, then restored.
    t = plan_keys[32];
    push_load(IndexW'(32), FieldMin + 1, 7);
    push_query(plan_keys[40]);
    push_query(plan_keys[20]);
    push_load(IndexW'(32), t, 0);
    push_query(rand_between(plan_keys[32], plan_keys[33]));

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Hold the random words back until the directed words have all come back.
    wait_for_drain();

    count = 0;
    next_reload = 250;
    while (count < RandomWords) begin
      if (count >= next_reload) begin
        pick = $urandom_range(0, 2);
        fill_table((pick == 0) ? 64'sd3 : (pick == 1) ? 64'sd65536 : 64'sd67108864);
        count += TABLE_DEPTH;
        next_reload += 300;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 58) begin
          i  = $urandom_range(0, TABLE_DEPTH - 2);
          lo = plan_keys[i];
          hi = plan_keys[i + 1];
          push_query((lo <= hi) ? rand_between(lo, hi) : rand_between(hi, lo));
        end else if (pick < 68) begin
          push_query(plan_keys[$urandom_range(0, TABLE_DEPTH - 1)]);
        end else if (pick < 72) begin
          q = plan_keys[0];
          push_query((q > FieldMin) ? rand_between(FieldMin, q - 1) : q);
        end else if (pick < 76) begin
          q = plan_keys[TABLE_DEPTH - 1];
          push_query((q < FieldMax) ? rand_between(q + 1, FieldMax) : q);
        end else if (pick < 81) begin
          push_query(longint'($signed($urandom)));
        end else if (pick < 93) begin
          i  = $urandom_range(0, TABLE_DEPTH - 1);
          lo = (i == 0) ? FieldMin : plan_keys[i - 1];
          hi = (i == TABLE_DEPTH - 1) ? FieldMax : plan_keys[i + 1];
          push_load(IndexW'(i), (lo <= hi) ? rand_between(lo, hi) : rand_between(hi, lo),
                    random_value());
        end else if (pick < 96) begin
          push_load(IndexW'($urandom_range(0, TABLE_DEPTH - 1)),
                    longint'($signed($urandom)), random_value());
        end else begin
          push_load(IndexW'($urandom_range(TABLE_DEPTH, 2 ** IndexW - 1)),
                    longint'($signed($urandom)), random_value());
        end
        count++;
      end
    end

    wait_for_drain();
    repeat (TailCycles) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
